// ===== sv/lscs_pkg.sv =====
// Shared constants, codes and types of the line-scan camera sequencer.
package lscs_pkg;

   // Sensor geometry
   localparam int PIXELS    = 128;
   localparam int IDX_W     = $clog2(PIXELS);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int EDGE_MAX  = 2 * PIXELS;
   localparam int EDGE_W    = $clog2(EDGE_MAX + 1);

   // Field and register widths
   localparam int OPCODE_W   = 2;
   localparam int SAMPLE_W   = 8;
   localparam int PIXIDX_W   = 7;
   localparam int PERIOD_W   = 16;
   localparam int INTERVAL_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register reset values
   localparam logic [PERIOD_W-1:0]   QUARTER_RESET  = 16'd250;
   localparam logic [PERIOD_W-1:0]   HALF_RESET     = 16'd500;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd100000;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_QUARTER  = 2'd0,
      REG_HALF     = 2'd1,
      REG_INTERVAL = 2'd2
   } reg_index_type;

   // Line sequencer phase: the action taken when the line timer next fires
   typedef enum logic [1:0] {
      PH_SI_RAISE    = 2'd0,
      PH_CLK_HIGH    = 2'd1,
      PH_SI_DROP     = 2'd2,
      PH_PIXEL_START = 2'd3
   } phase_type;

   // Item class after decode; KIND_IDLE changes nothing and reads zero
   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_IDLE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [SAMPLE_W-1:0]   sample;
      logic [IDX_W-1:0]      index;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

// ===== sv/lscs_front.sv =====
// Front end: accepts and classifies items and holds them in a short queue.
module lscs_front
   import lscs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [PIXIDX_W-1:0] req_pixel_index,
   output queue_head_type      head,
   input  logic                pop
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;
   entry_type              decoded;
   logic                   push;

   // Classify; a read beyond the line behaves as an idle item
   always_comb begin
      decoded.sample = req_sample;
      decoded.index  = IDX_W'(req_pixel_index);
      case (opcode_type'(req_opcode))
         OP_TICK:   decoded.kind = KIND_TICK;
         OP_SAMPLE: decoded.kind = KIND_SAMPLE;
         OP_READ: begin
            if (int'(req_pixel_index) < PIXELS) decoded.kind = KIND_READ;
            else                                decoded.kind = KIND_IDLE;
         end
         default:   decoded.kind = KIND_IDLE;
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid & ~req_stall;

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= decoded;
   end

endmodule

// ===== sv/lscs_back.sv =====
// Back end: timers, pin sequencing, line store and result registers.
module lscs_back
   import lscs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  queue_head_type        head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clk_level,
   output logic                  rsp_si_level,
   output logic                  rsp_adc_start,
   output logic                  rsp_line_done,
   output logic [SAMPLE_W-1:0]   rsp_read_data
);

   // Configuration
   logic [PERIOD_W-1:0]   quarter_ff;
   logic [PERIOD_W-1:0]   half_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // Sequencer state
   phase_type             phase_ff, phase_in;
   logic [INTERVAL_W-1:0] line_cd_ff, line_cd_in;
   logic [PERIOD_W-1:0]   pix_cd_ff, pix_cd_in;
   logic                  pix_on_ff, pix_on_in;
   logic [EDGE_W-1:0]     edge_ff, edge_in;
   logic                  parity_ff, parity_in;
   logic                  clk_ff, clk_in;
   logic                  si_ff, si_in;
   logic                  fill_ff, fill_in;
   logic                  adc_in, done_in;

   // Line store
   logic [SAMPLE_W-1:0]   mem [MEM_DEPTH];
   logic [SAMPLE_W-1:0]   rd_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;

   // Result pipeline
   logic                  s1_vld_ff, s1_vld_in;
   logic                  s1_clk_ff, s1_si_ff, s1_adc_ff, s1_done_ff, s1_read_ff;
   logic                  out_vld_ff, out_vld_in;
   logic                  s1_adv, s2_take, s2_free, s1_free;
   logic                  is_tick, line_fire, pix_fire;

   assign s2_take = out_vld_ff & ~rsp_stall;
   assign s2_free = ~out_vld_ff | s2_take;
   assign s1_adv  = s1_vld_ff & s2_free;
   assign s1_free = ~s1_vld_ff | s1_adv;
   assign pop     = head.valid & s1_free;

   assign s1_vld_in  = pop | (s1_vld_ff & ~s1_adv);
   assign out_vld_in = s1_adv | (out_vld_ff & ~s2_take);

   assign is_tick   = pop & (head.entry.kind == KIND_TICK);
   assign line_fire = (line_cd_ff <= INTERVAL_W'(1));
   assign pix_fire  = (pix_cd_ff <= PERIOD_W'(1));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_tick && line_fire) begin
         case (phase_ff)
            PH_SI_RAISE:    phase_in = PH_CLK_HIGH;
            PH_CLK_HIGH:    phase_in = PH_SI_DROP;
            PH_SI_DROP:     phase_in = PH_PIXEL_START;
            PH_PIXEL_START: phase_in = PH_SI_RAISE;
            default:        phase_in = PH_SI_RAISE;
         endcase
      end
   end

   // Timer, pin and pixel clock updates
   always_comb begin
      line_cd_in = line_cd_ff;
      pix_cd_in  = pix_cd_ff;
      pix_on_in  = pix_on_ff;
      edge_in    = edge_ff;
      parity_in  = parity_ff;
      clk_in     = clk_ff;
      si_in      = si_ff;
      fill_in    = fill_ff;
      adc_in     = 1'b0;
      done_in    = 1'b0;
      if (is_tick) begin
         if (line_fire) begin
            pix_on_in  = 1'b0;
            line_cd_in = INTERVAL_W'(quarter_ff);
            case (phase_ff)
               PH_SI_RAISE: begin
                  clk_in    = 1'b0;
                  fill_in   = ~fill_ff;
                  done_in   = 1'b1;
                  si_in     = 1'b1;
                  edge_in   = EDGE_W'(1);
                  parity_in = 1'b1;
               end
               PH_CLK_HIGH: clk_in = 1'b1;
               PH_SI_DROP:  si_in  = 1'b0;
               default: begin
                  clk_in     = 1'b0;
                  adc_in     = 1'b1;
                  pix_on_in  = 1'b1;
                  pix_cd_in  = half_ff;
                  line_cd_in = interval_ff;
               end
            endcase
         end else begin
            line_cd_in = line_cd_ff - 1'b1;
            if (pix_on_ff) begin
               if (pix_fire) begin
                  pix_cd_in = half_ff;
                  if (!parity_ff) begin
                     clk_in = 1'b0;
                     adc_in = 1'b1;
                  end else begin
                     clk_in = 1'b1;
                  end
                  parity_in = ~parity_ff;
                  if (edge_ff < EDGE_W'(EDGE_MAX)) edge_in = edge_ff + 1'b1;
               end else begin
                  pix_cd_in = pix_cd_ff - 1'b1;
               end
            end
         end
      end
   end

   // Samples fill pixel edge/2 of the filling half; reads take the other half
   assign mem_we  = pop & (head.entry.kind == KIND_SAMPLE) & (edge_ff < EDGE_W'(EDGE_MAX));
   assign mem_re  = pop & (head.entry.kind == KIND_READ);
   assign wr_addr = {fill_ff, IDX_W'(edge_ff >> 1)};
   assign rd_addr = {~fill_ff, head.entry.index};

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= head.entry.sample;
      if (mem_re) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff  <= QUARTER_RESET;
         half_ff     <= HALF_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_QUARTER:  quarter_ff  <= csr_data[PERIOD_W-1:0];
            REG_HALF:     half_ff     <= csr_data[PERIOD_W-1:0];
            REG_INTERVAL: interval_ff <= csr_data[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SI_RAISE;
         line_cd_ff <= INTERVAL_W'(QUARTER_RESET);
         pix_cd_ff  <= '0;
         pix_on_ff  <= 1'b0;
         edge_ff    <= '0;
         parity_ff  <= 1'b0;
         clk_ff     <= 1'b0;
         si_ff      <= 1'b0;
         fill_ff    <= 1'b0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         line_cd_ff <= line_cd_in;
         pix_cd_ff  <= pix_cd_in;
         pix_on_ff  <= pix_on_in;
         edge_ff    <= edge_in;
         parity_ff  <= parity_in;
         clk_ff     <= clk_in;
         si_ff      <= si_in;
         fill_ff    <= fill_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_clk_ff  <= clk_in;
         s1_si_ff   <= si_in;
         s1_adc_ff  <= adc_in;
         s1_done_ff <= done_in;
         s1_read_ff <= mem_re;
      end
      if (s1_adv) begin
         rsp_clk_level <= s1_clk_ff;
         rsp_si_level  <= s1_si_ff;
         rsp_adc_start <= s1_adc_ff;
         rsp_line_done <= s1_done_ff;
         rsp_read_data <= s1_read_ff ? rd_ff : '0;
      end
   end

   assign rsp_valid = out_vld_ff;

endmodule

// ===== sv/line_scan_camera_sequencer.sv =====
// Top level of the line-scan camera sequencer.
//
// Drives the SI and CLK pins of a linear image sensor and gathers one line of
// samples into a ping-pong line store. Each item on the req_ channel is a time
// tick, an ADC sample or a read of the finished line; every item gives exactly
// one item on the rsp_ channel with the pin levels after it, the conversion
// start and line-done flags, and the read pixel (zero for anything but a read).
// An item moves when valid is high and stall is low.
// A taken item is held in the queue, then in the execute register, then in the
// result register, from which it is offered on rsp_.
// Throughput: one item per cycle while rsp_stall is low, set by the execute
// step and the one write or read of the line store per item.
// A two-entry queue parts the decoder from the execute side; behind it sit an
// execute register and the result register, so a stalled receiver holds the
// result while up to three further items are taken, then req_stall rises.
// Reset (synchronous, active high) restores the register defaults, parks the
// sequencer before SI start and empties the queue; the line store is not
// cleared and holds no line until one has been filled. The user must write
// registers through csr_ only while the block is idle; it does not check this.
module line_scan_camera_sequencer
   import lscs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [PIXIDX_W-1:0]   req_pixel_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clk_level,
   output logic                  rsp_si_level,
   output logic                  rsp_adc_start,
   output logic                  rsp_line_done,
   output logic [SAMPLE_W-1:0]   rsp_read_data
);

   queue_head_type head;
   logic           pop;

   // Decode and queue items
   lscs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_sample      (req_sample),
      .req_pixel_index (req_pixel_index),
      .head            (head),
      .pop             (pop)
   );

   // Advance timers, drive pins, fill and read the line store
   lscs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_clk_level (rsp_clk_level),
      .rsp_si_level  (rsp_si_level),
      .rsp_adc_start (rsp_adc_start),
      .rsp_line_done (rsp_line_done),
      .rsp_read_data (rsp_read_data)
   );

endmodule

// ===== dv/tb_line_scan_camera_sequencer.sv =====
// Self-checking testbench for the line-scan camera sequencer.
module tb_line_scan_camera_sequencer;
   import lscs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The opcode field is two bits wide; its fourth code is spare and must be ignored
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   // Give up after this many cycles in which neither channel moves an item
   localparam int QUIET_LIMIT = 1000;
   // Stop printing mismatch lines beyond this count; keep counting them
   localparam int PRINT_LIMIT = 200;

   typedef struct packed {
      logic                clk_level;
      logic                si_level;
      logic                adc_start;
      logic                line_done;
      logic [SAMPLE_W-1:0] read_data;
   } sensor_result_type;

   // Clock, reset and block ports; every input starts at a known value
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic [PIXIDX_W-1:0]   req_pixel_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_clk_level;
   logic                  rsp_si_level;
   logic                  rsp_adc_start;
   logic                  rsp_line_done;
   logic [SAMPLE_W-1:0]   rsp_read_data;

   // Predicted sensor state: register copies, line timer, pixel clock and pins
   logic [PERIOD_W-1:0]   quarter_cfg  = QUARTER_RESET;
   logic [PERIOD_W-1:0]   half_cfg     = HALF_RESET;
   logic [INTERVAL_W-1:0] interval_cfg = INTERVAL_RESET;
   phase_type             seq_phase    = PH_SI_RAISE;
   logic [INTERVAL_W-1:0] line_timer   = INTERVAL_W'(QUARTER_RESET);
   logic [PERIOD_W-1:0]   pixel_timer  = '0;
   logic                  pixel_run    = 1'b0;
   logic [EDGE_W-1:0]     edge_tally   = '0;
   logic                  parity       = 1'b0;
   logic                  clk_pin      = 1'b0;
   logic                  si_pin       = 1'b0;
   logic                  fill_half    = 1'b0;
   logic [SAMPLE_W-1:0]   line_copy [MEM_DEPTH];
   bit                    line_written [MEM_DEPTH];

   // Results still owed by the block, oldest first
   sensor_result_type results_due [$];
   sensor_result_type due;
   int  mismatches   = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   // Suppress idling on both channels while set
   bit  steady = 1'b0;

   line_scan_camera_sequencer DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_sample      (req_sample),
      .req_pixel_index (req_pixel_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_clk_level   (rsp_clk_level),
      .rsp_si_level    (rsp_si_level),
      .rsp_adc_start   (rsp_adc_start),
      .rsp_line_done   (rsp_line_done),
      .rsp_read_data   (rsp_read_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predicted sensor by one accepted item and return the pin result.
   // A tick either fires the line timer, which owns the tick and stops the pixel
   // clock (pixel start restarts it), or counts it down and lets the pixel clock run.
   function automatic sensor_result_type step_sensor(logic [OPCODE_W-1:0] op,
                                                     logic [SAMPLE_W-1:0] smp,
                                                     logic [PIXIDX_W-1:0] pix);
      sensor_result_type res;
      res = '0;
      case (op)
         OP_TICK: begin
            if (line_timer <= 1) begin
               // Line timer event: any pixel edge due on this tick is lost
               pixel_run = 1'b0;
               case (seq_phase)
                  PH_SI_RAISE: begin
                     clk_pin       = 1'b0;
                     fill_half     = ~fill_half;
                     res.line_done = 1'b1;
                     si_pin        = 1'b1;
                     edge_tally    = EDGE_W'(1);
                     parity        = 1'b1;
                     line_timer    = INTERVAL_W'(quarter_cfg);
                     seq_phase     = PH_CLK_HIGH;
                  end
                  PH_CLK_HIGH: begin
                     clk_pin    = 1'b1;
                     line_timer = INTERVAL_W'(quarter_cfg);
                     seq_phase  = PH_SI_DROP;
                  end
                  PH_SI_DROP: begin
                     si_pin     = 1'b0;
                     line_timer = INTERVAL_W'(quarter_cfg);
                     seq_phase  = PH_PIXEL_START;
                  end
                  default: begin
                     clk_pin       = 1'b0;
                     res.adc_start = 1'b1;
                     pixel_run     = 1'b1;
                     pixel_timer   = half_cfg;
                     line_timer    = interval_cfg;
                     seq_phase     = PH_SI_RAISE;
                  end
               endcase
            end else begin
               line_timer = line_timer - 1'b1;
               if (pixel_run) begin
                  if (pixel_timer <= 1) begin
                     // Pixel edge: falling edges start a conversion
                     pixel_timer = half_cfg;
                     if (!parity) begin
                        clk_pin       = 1'b0;
                        res.adc_start = 1'b1;
                     end else begin
                        clk_pin = 1'b1;
                     end
                     parity = ~parity;
                     if (edge_tally < EDGE_MAX)
                        edge_tally = edge_tally + 1'b1;
                  end else begin
                     pixel_timer = pixel_timer - 1'b1;
                  end
               end
            end
         end
         OP_SAMPLE: begin
            // Drop samples that arrive after the last pixel of the line
            if (edge_tally < EDGE_MAX) begin
               line_copy[{fill_half, edge_tally[IDX_W:1]}]    = smp;
               line_written[{fill_half, edge_tally[IDX_W:1]}] = 1'b1;
            end
         end
         OP_READ: res.read_data = line_copy[{~fill_half, pix[IDX_W-1:0]}];
         default: ;
      endcase
      res.clk_level = clk_pin;
      res.si_level  = si_pin;
      return res;
   endfunction

   // Find a written pixel of the finished line, scanning from start; -1 if none
   function automatic int pick_written(int start);
      int slot;
      for (int n = 0; n < PIXELS; n++) begin
         slot = (start + n) % PIXELS;
         if (line_written[(fill_half ? 0 : PIXELS) + slot])
            return slot;
      end
      return -1;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t: mismatch on %s in result %0d: got %0h, want %0h",
                  $realtime, what, results_seen, got, want);
      mismatches++;
   endtask

   // Offer one item, idling at random first, and predict it once it is taken
   task automatic send_item(logic [OPCODE_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                            logic [PIXIDX_W-1:0] pix);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_sample      <= smp;
      req_pixel_index <= pix;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      results_due.push_back(step_sensor(op, smp, pix));
   endtask

   // Send one random item by the given weights; the rest are spare opcodes.
   // Reads only ever address pixels of the finished line that hold a sample.
   task automatic send_random(int tick_pct, int sample_pct, int read_pct);
      logic [OPCODE_W-1:0] op;
      logic [PIXIDX_W-1:0] pix;
      int roll;
      int slot;
      roll = $urandom_range(99);
      pix  = PIXIDX_W'($urandom);
      if (roll < tick_pct) begin
         op = OP_TICK;
      end else if (roll < tick_pct + sample_pct) begin
         op = OP_SAMPLE;
      end else if (roll < tick_pct + sample_pct + read_pct) begin
         slot = pick_written($urandom_range(PIXELS - 1));
         if (slot < 0) begin
            op = OP_SAMPLE;
         end else begin
            op  = OP_READ;
            pix = slot[PIXIDX_W-1:0];
         end
      end else begin
         op = OP_SPARE;
      end
      send_item(op, SAMPLE_W'($urandom), pix);
   endtask

   // Hold the sender back until every owed result is in, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (results_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers back to back while idle; mirror them in the model
   task automatic program_regs(logic [CSR_DATA_W-1:0] quarter, logic [CSR_DATA_W-1:0] half,
                               logic [CSR_DATA_W-1:0] interval);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= REG_QUARTER;
      csr_data  <= quarter;
      @(posedge clock);
      csr_index <= REG_HALF;
      csr_data  <= half;
      @(posedge clock);
      csr_index <= REG_INTERVAL;
      csr_data  <= interval;
      @(posedge clock);
      csr_write    <= 1'b0;
      quarter_cfg  = quarter[PERIOD_W-1:0];
      half_cfg     = half[PERIOD_W-1:0];
      interval_cfg = interval[INTERVAL_W-1:0];
   endtask

   // Reset defaults: spare opcodes at field extremes, ticks and samples before any line
   task automatic test_reset_state();
      send_item(OP_SPARE, 8'hFF, 7'h7F);
      send_item(OP_SPARE, 8'h00, 7'h00);
      send_item(OP_SAMPLE, 8'h00, 7'h7F);
      send_item(OP_SAMPLE, 8'hFF, 7'h00);
      send_item(OP_TICK, 8'h5A, 7'h2A);
      send_item(OP_TICK, 8'hA5, 7'h55);
      send_item(OP_SAMPLE, 8'hA5, 7'h00);
   endtask

   // Zero periods act as one: the line timer fires on every tick but the one counted
   // down after pixel start, and a pixel edge due with a line event must be swallowed
   task automatic test_zero_registers();
      int slot;
      program_regs('0, '0, 24'd2);
      // Run out the reset countdown, which still holds the old quarter period
      while (line_timer > 1)
         send_item(OP_TICK, SAMPLE_W'($urandom), PIXIDX_W'($urandom));
      send_item(OP_TICK, SAMPLE_W'($urandom), PIXIDX_W'($urandom));
      slot = pick_written(0);
      if (slot >= 0)
         send_item(OP_READ, SAMPLE_W'($urandom), slot[PIXIDX_W-1:0]);
      repeat (6) begin
         send_item(OP_TICK, SAMPLE_W'($urandom), PIXIDX_W'($urandom));
         send_item(OP_TICK, SAMPLE_W'($urandom), PIXIDX_W'($urandom));
         send_item(OP_SAMPLE, SAMPLE_W'($urandom), PIXIDX_W'($urandom));
      end
   endtask

   // Short lines that end before the pixel count saturates; pause now and then
   // until every result is back
   task automatic test_short_lines();
      program_regs(24'd1, 24'd2, 24'd60);
      for (int n = 0; n < 120; n++) begin
         if (n % 55 == 54)
            wait_idle();
         send_random(65, 20, 10);
      end
   endtask

   // Lines long enough to fill every pixel and then drop late samples; no idling
   task automatic test_full_lines();
      program_regs(24'd2, 24'd1, 24'd280);
      steady = 1'b1;
      repeat (420) send_random(78, 15, 5);
      steady = 1'b0;
   endtask

   // Largest register values, with the upper write bits set for the short registers
   task automatic test_register_extremes();
      program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      repeat (40) send_random(60, 20, 15);
   endtask

   // Stall the result channel at random except in the steady stretch
   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 36);

   // Compare each taken result with the oldest prediction, field by field
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            flag_mismatch("unexpected result", 32'd1, 32'd0);
         end else begin
            due = results_due.pop_front();
            if (rsp_clk_level !== due.clk_level)
               flag_mismatch("clk_level", 32'(rsp_clk_level), 32'(due.clk_level));
            if (rsp_si_level !== due.si_level)
               flag_mismatch("si_level", 32'(rsp_si_level), 32'(due.si_level));
            if (rsp_adc_start !== due.adc_start)
               flag_mismatch("adc_start", 32'(rsp_adc_start), 32'(due.adc_start));
            if (rsp_line_done !== due.line_done)
               flag_mismatch("line_done", 32'(rsp_line_done), 32'(due.line_done));
            if (rsp_read_data !== due.read_data)
               flag_mismatch("read_data", 32'(rsp_read_data), 32'(due.read_data));
         end
         results_seen++;
      end
   end

   // Abort when neither channel has moved an item for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_zero_registers();
      test_short_lines();
      test_full_lines();
      test_register_extremes();
      wait_idle();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
